>>> hdl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants of the 4x4 matrix by vector transform: payload
// structs, the token that runs down the cell chain and the coefficient reset.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  // word and fixed point format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_BITS;
  // four exact products need two more bits
  localparam int SUM_W     = PROD_W + 2;

  // matrix shape
  localparam int NUM_COLS  = 4;
  localparam int NUM_ROWS  = 4;
  localparam int COL_W     = $clog2(NUM_COLS);

  // configuration registers
  localparam int NUM_CFG   = 2 * NUM_COLS;
  localparam int CFG_SEL_W = $clog2(NUM_CFG);
  localparam int CFG_IDX_W = CFG_SEL_W + 1;
  localparam int CFG_W     = 2 * WORD_BITS;

  // register indexes
  localparam logic [CFG_SEL_W-1:0] REG_COL0_ROWS01 = 3'd0;
  localparam logic [CFG_SEL_W-1:0] REG_COL0_ROWS23 = 3'd1;
  localparam logic [CFG_SEL_W-1:0] REG_COL1_ROWS01 = 3'd2;
  localparam logic [CFG_SEL_W-1:0] REG_COL1_ROWS23 = 3'd3;
  localparam logic [CFG_SEL_W-1:0] REG_COL2_ROWS01 = 3'd4;
  localparam logic [CFG_SEL_W-1:0] REG_COL2_ROWS23 = 3'd5;
  localparam logic [CFG_SEL_W-1:0] REG_COL3_ROWS01 = 3'd6;
  localparam logic [CFG_SEL_W-1:0] REG_COL3_ROWS23 = 3'd7;

  // column selects of the cells
  localparam logic [COL_W-1:0] COL_X = 2'd0;
  localparam logic [COL_W-1:0] COL_Y = 2'd1;
  localparam logic [COL_W-1:0] COL_Z = 2'd2;
  localparam logic [COL_W-1:0] COL_W_SEL = 2'd3;

  // register stages: two per cell plus the output stage
  localparam int LATENCY   = 2 * NUM_COLS + 1;
  localparam int INFL_W    = $clog2(LATENCY + 1);

  // saturation limits
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Q16.16 one placed in the low or the high half of a register
  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(64'd1 << (FRAC_BITS + WORD_BITS));

  typedef struct packed {
    logic signed [WORD_BITS-1:0] vec_x;
    logic signed [WORD_BITS-1:0] vec_y;
    logic signed [WORD_BITS-1:0] vec_z;
    logic signed [WORD_BITS-1:0] vec_w;
  } vec_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] out_x;
    logic signed [WORD_BITS-1:0] out_y;
    logic signed [WORD_BITS-1:0] out_z;
    logic signed [WORD_BITS-1:0] out_w;
    logic                        saturated;
  } res_t;

  // item travelling down the chain with its running row sums
  typedef struct packed {
    logic                               valid;
    vec_t                               vec;
    logic [NUM_ROWS-1:0][SUM_W-1:0]     sums;
  } tok_t;

  typedef logic [NUM_ROWS-1:0][WORD_BITS-1:0] col_coef_t;

  // identity matrix after reset
  function automatic logic [CFG_W-1:0] cfg_reset_val(input logic [CFG_SEL_W-1:0] idx);
    logic [CFG_W-1:0] val;
    case (idx)
      REG_COL0_ROWS01: val = ONE_LO;
      REG_COL1_ROWS01: val = ONE_HI;
      REG_COL2_ROWS23: val = ONE_LO;
      REG_COL3_ROWS23: val = ONE_HI;
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hdl/m4vt_cell.sv
// ----------------------------------------------------------------------------
// m4vt_cell
// One column cell: multiplies its vector component by the four coefficients
// of its column, then adds the products onto the row sums handed in.
// ----------------------------------------------------------------------------
module m4vt_cell
  import m4vt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [COL_W-1:0] col_i,
  input  col_coef_t        coef_i,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic                                valid1_q, valid2_q;
  vec_t                                vec1_q, vec2_q;
  logic [NUM_ROWS-1:0][SUM_W-1:0]      sums1_q, sums2_q;
  logic [NUM_ROWS-1:0][PROD_W-1:0]     prod_q, prod_d;
  logic [NUM_ROWS-1:0][SUM_W-1:0]      sums2_d;
  logic signed [WORD_BITS-1:0]         comp;

  // pick this column's vector component
  always_comb begin
    case (col_i)
      COL_X:     comp = tok_i.vec.vec_x;
      COL_Y:     comp = tok_i.vec.vec_y;
      COL_Z:     comp = tok_i.vec.vec_z;
      COL_W_SEL: comp = tok_i.vec.vec_w;
      default:   comp = tok_i.vec.vec_x;
    endcase
  end

  // exact products, one multiplier per row
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_d[r] = PROD_W'($signed(coef_i[r])) * PROD_W'(comp);
    end
  end

  // accumulate onto the incoming row sums
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sums2_d[r] = SUM_W'($signed(sums1_q[r]) + $signed(SUM_W'($signed(prod_q[r]))));
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= tok_i.valid;
      valid2_q <= valid1_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec1_q  <= tok_i.vec;
      sums1_q <= tok_i.sums;
      prod_q  <= prod_d;
      vec2_q  <= vec1_q;
      sums2_q <= sums2_d;
    end
  end

  assign tok_o.valid = valid2_q;
  assign tok_o.vec   = vec2_q;
  assign tok_o.sums  = sums2_q;

endmodule

>>> hdl/m4vt_sat.sv
// ----------------------------------------------------------------------------
// m4vt_sat
// Output stage: drops the fraction bits of each row sum, clamps to the word
// range, flags any clamp and holds the item until it is taken.
// ----------------------------------------------------------------------------
module m4vt_sat
  import m4vt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  tok_t tok_i,
  output logic out_valid_o,
  output res_t out_o
);

  localparam int TOP_LO = FRAC_BITS + WORD_BITS - 1;

  logic [NUM_ROWS-1:0][WORD_BITS-1:0] lane;
  logic [NUM_ROWS-1:0]                ovf;
  logic                               out_valid_q;
  res_t                               out_q, out_d;

  // floor shift and clamp per row
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      ovf[r] = !((&tok_i.sums[r][SUM_W-1:TOP_LO]) || !(|tok_i.sums[r][SUM_W-1:TOP_LO]));
      if (ovf[r]) begin
        lane[r] = tok_i.sums[r][SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        lane[r] = tok_i.sums[r][TOP_LO:FRAC_BITS];
      end
    end
  end

  always_comb begin
    out_d.out_x     = lane[0];
    out_d.out_y     = lane[1];
    out_d.out_z     = lane[2];
    out_d.out_w     = lane[3];
    out_d.saturated = |ovf;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> hdl/matrix4_vector_transform.sv
// Stages from input item to output item: two per column cell, four cells, one
// output stage.
// Throughput: one item per cycle; the whole chain advances together and halts
// only while the output holds an item that is not taken.
// Reset: all valid bits clear, coefficient registers return to the identity matrix.
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Streams 4-component Q16.16 vectors through a chain of four column cells,
// each adding its column's contribution to the running row sums.
// ----------------------------------------------------------------------------
module matrix4_vector_transform
  import m4vt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vec_t                 in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [NUM_CFG-1:0][CFG_W-1:0] cfg_q;
  tok_t                          tok [NUM_COLS+1];
  logic                          en;
  logic [INFL_W-1:0]             infl_q;

  // chain advances unless the output item is stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // coefficient registers, out-of-range indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= cfg_reset_val(CFG_SEL_W'(i));
      end
    end else if (cfg_we_i && !cfg_idx_i[CFG_IDX_W-1]) begin
      cfg_q[cfg_idx_i[CFG_SEL_W-1:0]] <= cfg_wdata_i;
    end
  end

  // head of the chain: empty row sums
  assign tok[0].valid = in_valid_i;
  assign tok[0].vec   = in_i;
  assign tok[0].sums  = '0;

  // one cell per matrix column
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_cell
    col_coef_t coef;

    assign coef[0] = cfg_q[2*c][WORD_BITS-1:0];
    assign coef[1] = cfg_q[2*c][CFG_W-1:WORD_BITS];
    assign coef[2] = cfg_q[2*c+1][WORD_BITS-1:0];
    assign coef[3] = cfg_q[2*c+1][CFG_W-1:WORD_BITS];

    m4vt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .col_i  (COL_W'(c)),
      .coef_i (coef),
      .tok_i  (tok[c]),
      .tok_o  (tok[c+1])
    );
  end

  m4vt_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tok_i       (tok[NUM_COLS]),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // items in flight, for checking only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
    end else begin
      infl_q <= INFL_W'(infl_q + INFL_W'(in_valid_i && in_ready_o)
                - INFL_W'(out_valid_o && out_ready_i));
    end
  end

  // the chain never holds more items than it has stages
  a_infl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q <= INFL_W'(LATENCY))
    else $error("more items in flight than pipeline stages");

  // an output item must come from an accepted input item
  a_out_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> infl_q != '0)
    else $error("output item with nothing in flight");

  // the saturation flag implies a clamped component
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.saturated) |->
      (out_o.out_x == WORD_MAX || out_o.out_x == WORD_MIN ||
       out_o.out_y == WORD_MAX || out_o.out_y == WORD_MIN ||
       out_o.out_z == WORD_MAX || out_o.out_z == WORD_MIN ||
       out_o.out_w == WORD_MAX || out_o.out_w == WORD_MIN))
    else $error("saturated item without a clamped component");

  // writes beyond the register list leave the matrix alone
  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i[CFG_IDX_W-1]) |=> $stable(cfg_q))
    else $error("out-of-range register write changed the matrix");

endmodule
